[src/vdt_pkg.sv]
// ----------------------------------------------------------------------------
// Vertex deduplication table package
// Shared widths, operation and status codes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package vdt_pkg;

	localparam int unsigned COORD_W          = 16;
	localparam int unsigned KEY_W            = 3 * COORD_W;
	localparam int unsigned CNT_W            = 11;
	localparam int unsigned IDX_W            = 10;
	localparam int unsigned FUNC_W           = 2;
	localparam int unsigned MAX_VERTICES_DEF = 1024;
	localparam logic [CNT_W-1:0] CAP_RESET   = 11'd1024;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_FIND   = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_CLEAR  = 2'd2,
		FUNC_REDUCE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_FOUND      = 2'd0,
		ST_INSERTED   = 2'd1,
		ST_FULL       = 2'd2,
		ST_COUNT_DONE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_SCAN,
		S_INSERT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic accept;
		logic issue_read;
		logic set_found;
		logic insert;
		logic count_op;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic is_find;
		logic is_append;
		logic scan_more;
		logic rd_pending;
		logic rd_hit;
		logic out_free;
	} dp_sts_t;

endpackage

[src/vdt_if.sv]
// ----------------------------------------------------------------------------
// Vertex deduplication table channels
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vdt_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [vdt_pkg::FUNC_W-1:0]           func;
	logic signed [vdt_pkg::COORD_W-1:0]   coord_x;
	logic signed [vdt_pkg::COORD_W-1:0]   coord_y;
	logic signed [vdt_pkg::COORD_W-1:0]   coord_z;
	logic [vdt_pkg::CNT_W-1:0]            reduce_by;

	modport source (output valid, func, coord_x, coord_y, coord_z, reduce_by, input ready);
	modport sink (input valid, func, coord_x, coord_y, coord_z, reduce_by, output ready);
endinterface

interface vdt_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [vdt_pkg::IDX_W-1:0]   vertex_index;
	logic [1:0]                  status;
	logic [vdt_pkg::CNT_W-1:0]   vertex_count;

	modport source (output valid, vertex_index, status, vertex_count, input ready);
	modport sink (input valid, vertex_index, status, vertex_count, output ready);
endinterface

interface vdt_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [vdt_pkg::CNT_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[src/vdt_ctrl.sv]
// ----------------------------------------------------------------------------
// Vertex deduplication table controller
// Sequences one request at a time: load, search, insert and result hand-off.
// ----------------------------------------------------------------------------
module vdt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  vdt_pkg::dp_sts_t sts,
	output vdt_pkg::dp_cmd_t cmd
);

	vdt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vdt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			vdt_pkg::S_IDLE: begin
				if (in_valid) state_d = vdt_pkg::S_LOAD;
			end
			vdt_pkg::S_LOAD: begin
				if (sts.is_find) state_d = vdt_pkg::S_SCAN;
				else if (sts.is_append) state_d = vdt_pkg::S_INSERT;
				else state_d = vdt_pkg::S_FIN;
			end
			vdt_pkg::S_SCAN: begin
				if (sts.rd_hit) state_d = vdt_pkg::S_FIN;
				else if (!sts.scan_more && !sts.rd_pending) state_d = vdt_pkg::S_INSERT;
			end
			vdt_pkg::S_INSERT: begin
				state_d = vdt_pkg::S_FIN;
			end
			vdt_pkg::S_FIN: begin
				if (sts.out_free) state_d = vdt_pkg::S_IDLE;
			end
			default: begin
				state_d = vdt_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			vdt_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			vdt_pkg::S_LOAD: begin
				cmd.count_op = !sts.is_find && !sts.is_append;
			end
			vdt_pkg::S_SCAN: begin
				cmd.issue_read = sts.scan_more;
				cmd.set_found  = sts.rd_hit;
			end
			vdt_pkg::S_INSERT: begin
				cmd.insert = 1'b1;
			end
			vdt_pkg::S_FIN: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("Result loaded while the output register still holds a beat.");

	a_accept_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == vdt_pkg::S_LOAD)
		else $error("An accepted request did not move the controller to its load step.");

	a_hit_leaves_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vdt_pkg::S_SCAN && sts.rd_hit) |=> state_q == vdt_pkg::S_FIN)
		else $error("A search hit did not end the search.");

endmodule

[src/vdt_dp.sv]
// ----------------------------------------------------------------------------
// Vertex deduplication table datapath
// Vertex memory, fill count, capacity register, search pipeline and
// output register.
// ----------------------------------------------------------------------------
module vdt_dp #(
	parameter int unsigned MAX_VERTICES = vdt_pkg::MAX_VERTICES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  vdt_pkg::dp_cmd_t                   cmd,
	output vdt_pkg::dp_sts_t                   sts,
	input  logic [vdt_pkg::FUNC_W-1:0]         in_func,
	input  logic signed [vdt_pkg::COORD_W-1:0] in_x,
	input  logic signed [vdt_pkg::COORD_W-1:0] in_y,
	input  logic signed [vdt_pkg::COORD_W-1:0] in_z,
	input  logic [vdt_pkg::CNT_W-1:0]          in_reduce_by,
	input  logic                               cfg_we,
	input  logic [vdt_pkg::CNT_W-1:0]          cfg_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [vdt_pkg::IDX_W-1:0]          out_index,
	output logic [1:0]                         out_status,
	output logic [vdt_pkg::CNT_W-1:0]          out_count
);

	localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

	logic [vdt_pkg::KEY_W-1:0] mem [MAX_VERTICES];

	vdt_pkg::func_t            func_q;
	logic [vdt_pkg::KEY_W-1:0] key_q;
	logic [vdt_pkg::CNT_W-1:0] red_q;
	logic [vdt_pkg::CNT_W-1:0] fill_count_q;
	logic [vdt_pkg::CNT_W-1:0] cap_q;
	logic [vdt_pkg::CNT_W-1:0] scan_q;
	logic                      rd_valid_s1;
	logic [vdt_pkg::KEY_W-1:0] rd_data_s1;
	logic [AW-1:0]             idx_s1;
	logic [AW-1:0]             res_idx_q;
	vdt_pkg::status_t          res_status_q;
	logic                      out_valid_q;
	logic [vdt_pkg::IDX_W-1:0] out_index_q;
	vdt_pkg::status_t          out_status_q;
	logic [vdt_pkg::CNT_W-1:0] out_count_q;
	logic                      full;
	logic                      do_write;

	assign full = (fill_count_q >= cap_q) || (32'(fill_count_q) >= 32'(MAX_VERTICES));
	assign do_write = cmd.insert && !full;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= vdt_pkg::func_t'(in_func);
			key_q  <= {in_x, in_y, in_z};
			red_q  <= in_reduce_by;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[AW'(fill_count_q)] <= key_q;
		end
		if (cmd.issue_read) begin
			rd_data_s1 <= mem[AW'(scan_q)];
			idx_s1     <= AW'(scan_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count_q <= '0;
			cap_q        <= vdt_pkg::CAP_RESET;
			scan_q       <= '0;
			rd_valid_s1  <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.issue_read;
			if (cfg_we) cap_q <= cfg_data;
			if (cmd.accept) scan_q <= '0;
			else if (cmd.issue_read) scan_q <= scan_q + 1'b1;
			if (do_write) begin
				fill_count_q <= fill_count_q + 1'b1;
			end else if (cmd.count_op) begin
				if (func_q == vdt_pkg::FUNC_CLEAR || red_q >= fill_count_q) fill_count_q <= '0;
				else fill_count_q <= fill_count_q - red_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_found) begin
			res_idx_q    <= idx_s1;
			res_status_q <= vdt_pkg::ST_FOUND;
		end else if (cmd.insert) begin
			res_idx_q    <= full ? '0 : AW'(fill_count_q);
			res_status_q <= full ? vdt_pkg::ST_FULL : vdt_pkg::ST_INSERTED;
		end else if (cmd.count_op) begin
			res_idx_q    <= '0;
			res_status_q <= vdt_pkg::ST_COUNT_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_index_q  <= vdt_pkg::IDX_W'(res_idx_q);
			out_status_q <= res_status_q;
			out_count_q  <= fill_count_q;
		end
	end

	assign sts.is_find    = (func_q == vdt_pkg::FUNC_FIND);
	assign sts.is_append  = (func_q == vdt_pkg::FUNC_APPEND);
	assign sts.scan_more  = (scan_q < fill_count_q);
	assign sts.rd_pending = rd_valid_s1;
	assign sts.rd_hit     = rd_valid_s1 && (rd_data_s1 == key_q);
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_index  = out_index_q;
	assign out_status = out_status_q;
	assign out_count  = out_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_count_q) <= 32'(MAX_VERTICES))
		else $error("Fill count exceeds the store depth.");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		sts.rd_hit |-> 32'(idx_s1) < 32'(fill_count_q))
		else $error("Search hit on an entry beyond the fill count.");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |=> fill_count_q == $past(fill_count_q) + 1'b1)
		else $error("A stored vertex did not raise the fill count by one.");

endmodule

[src/vertex_dedup_table.sv]
// ----------------------------------------------------------------------------
// Vertex deduplication table
// Find-or-add store of 3D points with a fill count and a capacity register.
//
// Requests arrive on req (func, coord_x, coord_y, coord_z, reduce_by); every
// request gives exactly one beat on rsp (vertex_index, status, vertex_count).
// cfg writes the capacity limit and is always ready; write it only while
// no request is outstanding.
// Requests are handled one at a time. Every request passes a load step;
// clear and reduce then finish, append goes to the insert step, and
// find-or-add searches the store, reading the vertex memory one entry per
// cycle, and goes to the insert step on a miss. The next request is accepted
// in the cycle after the response is loaded into the output register.
// The output register holds a response while rsp.ready is low, and a new
// request is taken and processed meanwhile; its response waits until the
// register is free.
// Reset clears the fill count, sets the capacity to 1024 and empties the
// output register; the vertex memory is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module vertex_dedup_table #(
	parameter int unsigned MAX_VERTICES = vdt_pkg::MAX_VERTICES_DEF
) (
	input logic      clk,
	input logic      arst_n,
	vdt_req_if.sink  req,
	vdt_rsp_if.source rsp,
	vdt_cfg_if.sink  cfg
);

	vdt_pkg::dp_cmd_t cmd;
	vdt_pkg::dp_sts_t sts;
	logic             in_ready;

	assign req.ready = in_ready;
	assign cfg.ready = 1'b1;

	vdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vdt_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_func      (req.func),
		.in_x         (req.coord_x),
		.in_y         (req.coord_y),
		.in_z         (req.coord_z),
		.in_reduce_by (req.reduce_by),
		.cfg_we       (cfg.valid),
		.cfg_data     (cfg.data),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.out_index    (rsp.vertex_index),
		.out_status   (rsp.status),
		.out_count    (rsp.vertex_count)
	);

endmodule
